// ===== design/mwtg_pkg.sv =====
// Package for the multi-waveform tone generator.
// Holds sizes, register indexes, waveform codes, reset values and the sine table builder.
// No dependencies.
package mwtg_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int HARMONIC_COUNT  = 6;

  localparam int SINE_DEPTH = 1 << SINE_TABLE_BITS;
  localparam int TOTAL_W    = 16 + HARMONIC_COUNT;
  localparam int HCNT_W     = $clog2(HARMONIC_COUNT + 1);
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int PIANO_SHIFT = 16 + HARMONIC_COUNT - 1;
  localparam int PLAIN_SHIFT = 16;

  localparam logic [1:0] REG_PHASE_STEP   = 2'd0;
  localparam logic [1:0] REG_WAVEFORM     = 2'd1;
  localparam logic [1:0] REG_GAIN         = 2'd2;
  localparam logic [1:0] REG_DECAY_FACTOR = 2'd3;

  localparam logic [2:0] WAVE_SINE     = 3'd0;
  localparam logic [2:0] WAVE_SAWTOOTH = 3'd1;
  localparam logic [2:0] WAVE_TRIANGLE = 3'd2;
  localparam logic [2:0] WAVE_SQUARE   = 3'd3;
  localparam logic [2:0] WAVE_PIANO    = 3'd4;

  localparam logic [31:0] PHASE_STEP_RESET   = 32'd23409862;
  localparam logic [2:0]  WAVEFORM_RESET     = WAVE_PIANO;
  localparam logic [15:0] GAIN_RESET         = 16'd6554;
  localparam logic [31:0] DECAY_FACTOR_RESET = 32'd4294378886;

  typedef logic signed [15:0] sine_table_t [SINE_DEPTH];

  // Quarter-wave odd polynomial, evaluated at elaboration for every table entry.
  function automatic sine_table_t build_sine_table();
    sine_table_t tab;
    longint unsigned quarter;
    longint unsigned quad;
    longint unsigned q;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned y;
    quarter = longint'(1) << (SINE_TABLE_BITS - 2);
    for (int i = 0; i < SINE_DEPTH; i++) begin
      quad = (longint'(i) >> (SINE_TABLE_BITS - 2)) & 3;
      q    = longint'(i) & (quarter - 1);
      x    = quad[0] ? (quarter - q) : q;
      x    = x << (17 - SINE_TABLE_BITS);
      x2   = (x * x) >> 15;
      t    = 21167 - ((x2 * 2463) >> 15);
      t    = 51472 - ((x2 * t) >> 15);
      y    = (x * t) >> 15;
      if (y > 32767) y = 32767;
      tab[i] = (quad >= 2) ? -16'(y) : 16'(y);
    end
    return tab;
  endfunction

endpackage

// ===== design/multi_waveform_tone_generator_core.sv =====
// Direct digital synthesis tone generator: each accepted word is one sample tick and yields
// one signed Q1.15 sample word. A tick runs from acceptance to the result in the output
// register through these steps: the accept state, one sine table read per harmonic through the
// single table port plus a drain step, three back-to-back passes through the one shared
// 33 x 33 multiplier (envelope, gain, envelope decay), a step that stores the decayed envelope
// and advances the phase, and a step that loads the output register.
// The input side stalls for the whole tick, and for longer while the previous sample waits.
// Depends on mwtg_pkg, mwtg_sine_rom and mwtg_mul.
module multi_waveform_tone_generator_core
  import mwtg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               restart,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] sample
);

  typedef enum logic [2:0] {
    S_IDLE, S_HARM, S_HLAST, S_MUL_T, S_MUL_G, S_MUL_E, S_ENV, S_OUT
  } state_t;

  state_t state;

  logic [31:0] phase_step;
  logic [2:0]  wave;
  logic [15:0] gain;
  logic [31:0] decay_factor;

  logic [31:0] phase;
  logic [31:0] envelope;
  logic [31:0] ph_cur;
  logic [31:0] env_cur;
  logic [31:0] hph;
  logic [HCNT_W-1:0] hcnt;
  logic signed [TOTAL_W-1:0] total;
  logic signed [15:0] sine_w;
  logic acc_en;
  logic acc_first;
  logic signed [15:0] sat_s;

  logic signed [15:0] rom_data;
  logic signed [MUL_W-1:0] mul_a;
  logic [31:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;

  logic signed [15:0] saw_w;
  logic [16:0] saw_abs;
  logic signed [17:0] tri_v;
  logic signed [15:0] tri_w;
  logic signed [15:0] wave_w;
  logic signed [PROD_W-1:0] shifted;

  mwtg_sine_rom u_rom (
    .clk  (clk),
    .addr (hph[31 -: SINE_TABLE_BITS]),
    .data (rom_data)
  );

  mwtg_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign in_stall = (state != S_IDLE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step   <= PHASE_STEP_RESET;
      wave         <= WAVEFORM_RESET;
      gain         <= GAIN_RESET;
      decay_factor <= DECAY_FACTOR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PHASE_STEP:   phase_step   <= cfg_data;
        REG_WAVEFORM:     wave         <= cfg_data[2:0];
        REG_GAIN:         gain         <= cfg_data[15:0];
        REG_DECAY_FACTOR: decay_factor <= cfg_data;
        default: ;
      endcase
    end
  end

  // Plain waveforms from the tick's phase; the sawtooth is the top half with its sign bit flipped.
  always_comb begin
    saw_w   = $signed({~ph_cur[31], ph_cur[30:16]});
    saw_abs = saw_w[15] ? (17'd0 - 17'(saw_w)) : 17'(saw_w);
    tri_v   = $signed({1'b0, saw_abs}) + $signed({1'b0, saw_abs}) - 18'sd32768;
    tri_w   = (tri_v > 18'sd32767) ? 16'sh7FFF : tri_v[15:0];
    case (wave)
      WAVE_SINE:     wave_w = sine_w;
      WAVE_SAWTOOTH: wave_w = saw_w;
      WAVE_TRIANGLE: wave_w = tri_w;
      WAVE_SQUARE:   wave_w = ph_cur[31] ? 16'sh7FFF : 16'sh8000;
      default:       wave_w = 16'sh0000;
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (state)
      S_MUL_T: begin
        mul_a = MUL_W'(total);
        mul_b = env_cur;
      end
      S_MUL_G: begin
        mul_a = (wave == WAVE_PIANO) ? mul_p[32 +: MUL_W] : MUL_W'(wave_w);
        mul_b = 32'(gain);
      end
      S_MUL_E: begin
        mul_a = $signed({1'b0, env_cur});
        mul_b = decay_factor;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign shifted = (wave == WAVE_PIANO) ? (mul_p >>> PIANO_SHIFT) : (mul_p >>> PLAIN_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      acc_en    <= 1'b0;
      acc_first <= 1'b0;
      phase     <= '0;
      envelope  <= '1;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;

      acc_en    <= (state == S_HARM);
      acc_first <= (state == S_HARM) && (hcnt == '0);
      // Horner form: doubling the running sum weights harmonic k by 2^(H-k).
      if (acc_en) begin
        total <= {total[TOTAL_W-2:0], 1'b0} + TOTAL_W'(rom_data);
        if (acc_first) sine_w <= rom_data;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            ph_cur  <= restart ? '0 : phase;
            hph     <= restart ? '0 : phase;
            env_cur <= restart ? '1 : envelope;
            hcnt    <= '0;
            total   <= '0;
            state   <= S_HARM;
          end
        end
        S_HARM: begin
          hph  <= hph + ph_cur;
          hcnt <= hcnt + 1'b1;
          if (hcnt == HCNT_W'(HARMONIC_COUNT - 1)) state <= S_HLAST;
        end
        S_HLAST: state <= S_MUL_T;
        S_MUL_T: state <= S_MUL_G;
        S_MUL_G: state <= S_MUL_E;
        S_MUL_E: begin
          if (wave > WAVE_PIANO) begin
            sat_s <= 16'sh0000;
          end else if (shifted > PROD_W'(32767)) begin
            sat_s <= 16'sh7FFF;
          end else if (shifted < -PROD_W'(32768)) begin
            sat_s <= 16'sh8000;
          end else begin
            sat_s <= shifted[15:0];
          end
          state <= S_ENV;
        end
        S_ENV: begin
          envelope <= mul_p[63:32];
          phase    <= ph_cur + phase_step;
          state    <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            sample    <= sat_s;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input side not stalled after an accepted word");

  a_harm_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_HARM) |-> (hcnt < HCNT_W'(HARMONIC_COUNT)))
    else $error("harmonic counter out of range");

  a_env_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_ENV) |=> ($stable(envelope) && $stable(phase)))
    else $error("oscillator state changed outside its update step");

  a_out_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_valid && out_stall) |=> (state == S_OUT))
    else $error("result overwrote a sample still waiting");
`endif

endmodule

// ===== design/mwtg_sine_rom.sv =====
// Sine table with a registered read port.
// Depends on mwtg_pkg for the table size and the table builder.
module mwtg_sine_rom
  import mwtg_pkg::*;
(
  input  logic                        clk,
  input  logic [SINE_TABLE_BITS-1:0]  addr,
  output logic signed [15:0]          data
);

  localparam sine_table_t SINE_TABLE = build_sine_table();

  always_ff @(posedge clk) begin
    data <= SINE_TABLE[addr];
  end

endmodule

// ===== design/mwtg_mul.sv =====
// Shared signed multiplier with its product registered.
// Depends on mwtg_pkg for the operand and product widths.
module mwtg_mul
  import mwtg_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic        [31:0]       b,
  output logic signed [PROD_W-1:0] p
);

  logic signed [MUL_W-1:0] b_s;

  assign b_s = $signed({1'b0, b});

  always_ff @(posedge clk) begin
    p <= a * b_s;
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for multi_waveform_tone_generator_core: a short directed stimulus table followed by
// random register settings and sample ticks, each result checked against a fixed value or a tone predictor.
// Depends on mwtg_pkg and the core RTL only.
module testbench;
  import mwtg_pkg::*;

  localparam int N_ROWS          = 39;
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 70;
  localparam int CFG_SETTLE      = 16;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 30;
  localparam int CYCLE_LIMIT     = 400000;

  // Waveform codes with no defined shape; the core must output silence for them.
  localparam logic [2:0] WAVE_UNDEF_LO = 3'd5;
  localparam logic [2:0] WAVE_UNDEF_HI = 3'd7;

  logic               clk;
  logic               rst       = 1'b1;
  logic               cfg_we    = 1'b0;
  logic [1:0]         cfg_index = REG_PHASE_STEP;
  logic [31:0]        cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic               restart   = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] sample;

  multi_waveform_tone_generator_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .restart   (restart),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample    (sample)
  );

  // Shadow of the oscillator registers and state.
  logic [31:0] step_reg  = PHASE_STEP_RESET;
  logic [2:0]  wave_reg  = WAVEFORM_RESET;
  logic [15:0] gain_reg  = GAIN_RESET;
  logic [31:0] decay_reg = DECAY_FACTOR_RESET;
  logic [31:0] phase_acc = '0;
  logic [31:0] env_level = '1;

  logic signed [15:0] expected_samples [$];
  logic signed [15:0] oldest_sample;
  int  mismatches    = 0;
  int  cycle_count   = 0;
  int  hold_requests = 0;
  int  holds_served  = 0;
  bit  quiet_tail    = 1'b0;
  bit  no_gaps       = 1'b0;

  typedef struct packed {
    logic               is_cfg;
    logic [1:0]         reg_index;
    logic [31:0]        value;
    logic               restart_bit;
    logic               known;
    logic signed [15:0] want;
  } step_row_t;

  step_row_t script [N_ROWS] = '{
    // Reset settings: piano at phase zero is silent, then two predicted ticks.
    '{1'b0, REG_PHASE_STEP,   32'd0,                  1'b1, 1'b1, 16'sd0},
    '{1'b0, REG_PHASE_STEP,   32'd0,                  1'b0, 1'b0, 16'sd0},
    '{1'b0, REG_PHASE_STEP,   32'd0,                  1'b0, 1'b0, 16'sd0},
    // Square at full gain, half-cycle steps: both rails.
    '{1'b1, REG_PHASE_STEP,   32'h8000_0000,          1'b0, 1'b0, 16'sd0},
    '{1'b1, REG_WAVEFORM,     32'(WAVE_SQUARE),       1'b0, 1'b0, 16'sd0},
    '{1'b1, REG_GAIN,         32'h0000_FFFF,          1'b0, 1'b0, 16'sd0},
    '{1'b0, REG_PHASE_STEP,   32'd0,                  1'b1, 1'b1, 16'sh8000},
    '{1'b0, REG_PHASE_STEP,   32'd0,                  1'b0, 1'b1, 16'sd32766},
    // Sawtooth at both ends of the phase range.
    '{1'b1, REG_WAVEFORM,     32'(WAVE_SAWTOOTH),     1'b0, 1'b0, 16'sd0},
    '{1'b1, REG_PHASE_STEP,   32'hFFFF_FFFF,          1'b0, 1'b0, 16'sd0},
    '{1'b0, REG_PHASE_STEP,   32'd0,                  1'b1, 1'b1, 16'sh8000},
    '{1'b0, REG_PHASE_STEP,   32'd0,                  1'b0, 1'b1, 16'sd32766},
    // Triangle in quarter steps: clamped top, zero crossing, bottom.
    '{1'b1, REG_WAVEFORM,     32'(WAVE_TRIANGLE),     1'b0, 1'b0, 16'sd0},
    '{1'b1, REG_PHASE_STEP,   32'h4000_0000,          1'b0, 1'b0, 16'sd0},
    '{1'b0, REG_PHASE_STEP,   32'd0,                  1'b1, 1'b1, 16'sd32766},
    '{1'b0, REG_PHASE_STEP,   32'd0,                  1'b0, 1'b1, 16'sd0},
    '{1'b0, REG_PHASE_STEP,   32'd0,                  1'b0, 1'b1, 16'sh8000},
    // Sine in quarter steps.
    '{1'b1, REG_WAVEFORM,     32'(WAVE_SINE),         1'b0, 1'b0, 16'sd0},
    '{1'b0, REG_PHASE_STEP,   32'd0,                  1'b1, 1'b1, 16'sd0},
    '{1'b0, REG_PHASE_STEP,   32'd0,                  1'b0, 1'b0, 16'sd0},
    '{1'b0, REG_PHASE_STEP,   32'd0,                  1'b0, 1'b0, 16'sd0},
    '{1'b0, REG_PHASE_STEP,   32'd0,                  1'b0, 1'b0, 16'sd0},
    '{1'b1, REG_GAIN,         32'd0,                  1'b0, 1'b0, 16'sd0},
    '{1'b0, REG_PHASE_STEP,   32'd0,                  1'b0, 1'b1, 16'sd0},
    // Undefined waveform codes are silent even at full gain.
    '{1'b1, REG_WAVEFORM,     32'(WAVE_UNDEF_LO),     1'b0, 1'b0, 16'sd0},
    '{1'b1, REG_GAIN,         32'h0000_FFFF,          1'b0, 1'b0, 16'sd0},
    '{1'b0, REG_PHASE_STEP,   32'd0,                  1'b0, 1'b1, 16'sd0},
    '{1'b1, REG_WAVEFORM,     32'(WAVE_UNDEF_HI),     1'b0, 1'b0, 16'sd0},
    '{1'b0, REG_PHASE_STEP,   32'd0,                  1'b1, 1'b1, 16'sd0},
    // Piano at full gain with no decay (saturates), then a decay that kills the envelope.
    '{1'b1, REG_WAVEFORM,     32'(WAVE_PIANO),        1'b0, 1'b0, 16'sd0},
    '{1'b1, REG_DECAY_FACTOR, 32'hFFFF_FFFF,          1'b0, 1'b0, 16'sd0},
    '{1'b1, REG_PHASE_STEP,   32'h0010_0000,          1'b0, 1'b0, 16'sd0},
    '{1'b0, REG_PHASE_STEP,   32'd0,                  1'b1, 1'b1, 16'sd0},
    '{1'b0, REG_PHASE_STEP,   32'd0,                  1'b0, 1'b0, 16'sd0},
    '{1'b0, REG_PHASE_STEP,   32'd0,                  1'b0, 1'b0, 16'sd0},
    '{1'b1, REG_DECAY_FACTOR, 32'd0,                  1'b0, 1'b0, 16'sd0},
    '{1'b0, REG_PHASE_STEP,   32'd0,                  1'b0, 1'b0, 16'sd0},
    '{1'b0, REG_PHASE_STEP,   32'd0,                  1'b0, 1'b1, 16'sd0},
    '{1'b0, REG_PHASE_STEP,   32'd0,                  1'b1, 1'b1, 16'sd0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Quarter-wave odd polynomial sine, looked up by the top phase bits.
  function automatic int sine_point(logic [31:0] ph);
    longint unsigned idx, quarter, quad, q, x, x2, t, y;
    idx     = longint'(ph >> (32 - SINE_TABLE_BITS));
    quarter = longint'(1) << (SINE_TABLE_BITS - 2);
    quad    = (idx >> (SINE_TABLE_BITS - 2)) & 3;
    q       = idx & (quarter - 1);
    x       = ((quad & 1) != 0) ? (quarter - q) : q;
    x       = x << (17 - SINE_TABLE_BITS);
    x2      = (x * x) >> 15;
    t       = 21167 - ((x2 * 2463) >> 15);
    t       = 51472 - ((x2 * t) >> 15);
    y       = (x * t) >> 15;
    if (y > 32767) y = 32767;
    return (quad >= 2) ? -int'(y) : int'(y);
  endfunction

  // Computes the sample of one tick and advances phase and envelope.
  function automatic logic signed [15:0] advance_tone(bit restart_bit);
    int                 w, saw, k;
    longint             s, total;
    longint unsigned    env_prod;
    logic [31:0]        pk;
    logic signed [15:0] result;
    if (restart_bit) begin
      phase_acc = '0;
      env_level = '1;
    end
    saw = int'(phase_acc >> 16) - 32768;
    w   = 0;
    s   = 0;
    case (wave_reg)
      WAVE_SINE:     w = sine_point(phase_acc);
      WAVE_SAWTOOTH: w = saw;
      WAVE_TRIANGLE: begin
        w = 2 * ((saw < 0) ? -saw : saw) - 32768;
        if (w > 32767) w = 32767;
      end
      WAVE_SQUARE:   w = phase_acc[31] ? 32767 : -32768;
      default:       w = 0;
    endcase
    if (wave_reg <= WAVE_SQUARE) begin
      s = (longint'(w) * longint'({48'd0, gain_reg})) >>> 16;
    end else if (wave_reg == WAVE_PIANO) begin
      total = 0;
      for (k = 1; k <= HARMONIC_COUNT; k++) begin
        pk    = phase_acc * 32'(k);
        total = total + (longint'(sine_point(pk)) <<< (HARMONIC_COUNT - k));
      end
      s = (total * longint'({32'd0, env_level})) >>> 32;
      s = (s * longint'({48'd0, gain_reg})) >>> (16 + HARMONIC_COUNT - 1);
    end
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    result    = s[15:0];
    phase_acc = phase_acc + step_reg;
    env_prod  = ({32'd0, env_level} * {32'd0, decay_reg}) >> 32;
    env_level = env_prod[31:0];
    return result;
  endfunction

  // Registers change only with nothing in flight.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PHASE_STEP:   step_reg  = value;
      REG_WAVEFORM:     wave_reg  = value[2:0];
      REG_GAIN:         gain_reg  = value[15:0];
      REG_DECAY_FACTOR: decay_reg = value;
      default:          ;
    endcase
  endtask

  task automatic send_tick(bit restart_bit, bit known, logic signed [15:0] fixed_value);
    logic signed [15:0] predicted;
    in_valid <= 1'b1;
    restart  <= restart_bit;
    do @(posedge clk); while (in_stall);
    predicted = advance_tone(restart_bit);
    expected_samples.push_back(known ? fixed_value : predicted);
    if (!no_gaps && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      restart  <= 1'($urandom);
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  initial begin : stimulus
    int          ph, n;
    logic [31:0] pick;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (n = 0; n < N_ROWS; n++) begin
      if (script[n].is_cfg) write_reg(script[n].reg_index, script[n].value);
      else send_tick(script[n].restart_bit, script[n].known, script[n].want);
    end
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 5))
        0:       pick = '0;
        1:       pick = '1;
        2:       pick = $urandom_range(1, 32'h0100_0000);
        default: pick = $urandom;
      endcase
      write_reg(REG_PHASE_STEP, pick);
      pick = 32'($urandom_range(WAVE_SINE, WAVE_PIANO));
      if ($urandom_range(0, 3) == 0) pick = 32'(3'($urandom));
      write_reg(REG_WAVEFORM, pick);
      case ($urandom_range(0, 3))
        0:       pick = '0;
        1:       pick = 32'h0000_FFFF;
        default: pick = $urandom_range(0, 16'hFFFF);
      endcase
      write_reg(REG_GAIN, pick);
      case ($urandom_range(0, 3))
        0:       pick = '0;
        1:       pick = '1;
        2:       pick = $urandom;
        default: pick = 32'hFFFF_FFFF - $urandom_range(0, 32'h0010_0000);
      endcase
      write_reg(REG_DECAY_FACTOR, pick);
      quiet_tail = (ph == RANDOM_PHASES - 1);
      // In pressure phases the sender never pauses while the output side is held off.
      no_gaps = quiet_tail || (ph % 4 == 2);
      if (ph % 4 == 2) hold_requests++;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_tick(($urandom_range(0, 11) == 0) || (n == 0 && $urandom_range(0, 1) == 1),
                  1'b0, '0);
      end
    end
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : drain_side
    int free_run;
    @(posedge clk);
    forever begin
      if (hold_requests != holds_served) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_served++;
      end else if (quiet_tail) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        free_run = $urandom_range(1, 40);
        out_stall <= 1'b0;
        repeat (free_run) @(posedge clk);
        if (!quiet_tail && $urandom_range(0, 1) == 1) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 18)) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: sample word %0d arrived with nothing expected", $time, sample);
        mismatches++;
      end else begin
        oldest_sample = expected_samples.pop_front();
        if (sample !== oldest_sample) begin
          $display("%0t: sample expected %0d, actual %0d", $time, oldest_sample, sample);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
